FILE: rtl/lld_pkg.sv
// Package for the line-to-line distance pipeline: widths, payload structs
// and the shared arithmetic helpers. No dependencies.
package lld_pkg;

  localparam int FRAC_BITS = 16;
  localparam int XW        = 32;
  localparam int WW        = XW + 1;
  localparam int PRODW     = 2 * WW;
  localparam int SUMW      = PRODW + 2;
  localparam int DOTW      = SUMW - FRAC_BITS;
  localparam int KLO       = (DOTW + 1) / 2;
  localparam int KHI       = DOTW - KLO;
  localparam int BIGW      = 2 * DOTW;
  localparam int PW        = BIGW + 1;
  localparam int MAGW      = PW;
  localparam int NW        = MAGW + FRAC_BITS;
  localparam int QW        = 64;
  localparam int RW        = MAGW + 1;
  localparam int DSTEPS    = QW;
  localparam int TW        = 64;
  localparam int TPW       = TW + XW;
  localparam int RNDW      = TPW - FRAC_BITS;
  localparam int GW        = RNDW + 2;
  localparam int DW        = 32;
  localparam int SQW       = 2 * DW;
  localparam int SSW       = SQW + 2;
  localparam int ROOTW     = 34;
  localparam int CSQW      = 2 * ROOTW;

  localparam logic [QW-1:0] T_LIMIT = {2'b01, {(QW-2){1'b0}}};

  typedef logic [2:0][XW-1:0] vec_t;
  typedef logic [2:0][WW-1:0] wvec_t;

  typedef struct packed {
    vec_t  u;
    vec_t  v;
    wvec_t w;
    logic  neg1;
    logic  neg2;
    logic  par;
  } side_t;

  typedef struct packed {
    logic [MAGW-1:0] nmag1;
    logic [MAGW-1:0] nmag2;
    logic [MAGW-1:0] dmag;
    side_t           side;
  } dreq_t;

  typedef struct packed {
    logic [QW-1:0] q1;
    logic [QW-1:0] q2;
    logic          ovf1;
    logic          ovf2;
    side_t         side;
  } dres_t;

  typedef struct packed {
    logic [MAGW-1:0] d;
    logic [RW-1:0]   r1;
    logic [RW-1:0]   r2;
    logic [QW-1:0]   n1;
    logic [QW-1:0]   n2;
    logic [QW-1:0]   q1;
    logic [QW-1:0]   q2;
    logic            ovf1;
    logic            ovf2;
    side_t           side;
  } dstage_t;

  typedef struct packed {
    logic par;
    logic sat;
  } sflag_t;

  typedef struct packed {
    logic [SSW-1:0] sum;
    sflag_t         flg;
  } sreq_t;

  typedef struct packed {
    logic [ROOTW-1:0] root;
    sflag_t           flg;
  } sres_t;

  typedef struct packed {
    logic [SSW-1:0]   sum;
    logic [ROOTW-1:0] root;
    logic [CSQW-1:0]  sq;
    sflag_t           flg;
  } sqst_t;

  typedef struct packed {
    logic        [2*KLO-1:0]   ll;
    logic signed [KLO+KHI:0]   lh;
    logic signed [KLO+KHI:0]   hl;
    logic signed [2*KHI-1:0]   hh;
  } pp_t;

  // sum three products, round half up to FRAC_BITS fraction bits
  function automatic logic signed [DOTW-1:0] dot_round(
    input logic signed [PRODW-1:0] p0,
    input logic signed [PRODW-1:0] p1,
    input logic signed [PRODW-1:0] p2
  );
    logic signed [SUMW-1:0] s;
    s = SUMW'(p0) + SUMW'(p1) + SUMW'(p2) + (SUMW'(1) << (FRAC_BITS - 1));
    return s[SUMW-1:FRAC_BITS];
  endfunction

  function automatic pp_t pp_make(
    input logic signed [DOTW-1:0] x,
    input logic signed [DOTW-1:0] y
  );
    logic        [KLO-1:0] xl;
    logic        [KLO-1:0] yl;
    logic signed [KHI-1:0] xh;
    logic signed [KHI-1:0] yh;
    pp_t                   p;
    xl   = x[KLO-1:0];
    yl   = y[KLO-1:0];
    xh   = x[DOTW-1:KLO];
    yh   = y[DOTW-1:KLO];
    p.ll = xl * yl;
    p.lh = $signed({1'b0, xl}) * yh;
    p.hl = xh * $signed({1'b0, yl});
    p.hh = xh * yh;
    return p;
  endfunction

  function automatic logic signed [BIGW-1:0] pp_join(input pp_t p);
    return (BIGW'(p.hh) <<< (2 * KLO)) + (BIGW'(p.lh) <<< KLO)
         + (BIGW'(p.hl) <<< KLO) + BIGW'(p.ll);
  endfunction

endpackage

FILE: rtl/lld_in_if.sv
// Input channel: one pair of lines per transfer, valid/ready handshake.
// Depends on lld_pkg.
interface lld_in_if;
  import lld_pkg::*;
  logic          valid;
  logic          ready;
  logic [XW-1:0] first_point_x;
  logic [XW-1:0] first_point_y;
  logic [XW-1:0] first_point_z;
  logic [XW-1:0] first_dir_x;
  logic [XW-1:0] first_dir_y;
  logic [XW-1:0] first_dir_z;
  logic [XW-1:0] second_point_x;
  logic [XW-1:0] second_point_y;
  logic [XW-1:0] second_point_z;
  logic [XW-1:0] second_dir_x;
  logic [XW-1:0] second_dir_y;
  logic [XW-1:0] second_dir_z;

  modport source (
    output valid, first_point_x, first_point_y, first_point_z,
    output first_dir_x, first_dir_y, first_dir_z,
    output second_point_x, second_point_y, second_point_z,
    output second_dir_x, second_dir_y, second_dir_z,
    input  ready
  );
  modport sink (
    input  valid, first_point_x, first_point_y, first_point_z,
    input  first_dir_x, first_dir_y, first_dir_z,
    input  second_point_x, second_point_y, second_point_z,
    input  second_dir_x, second_dir_y, second_dir_z,
    output ready
  );
endinterface

FILE: rtl/lld_out_if.sv
// Result channel: distance and flags per transfer, valid/ready handshake.
// Depends on lld_pkg.
interface lld_out_if;
  import lld_pkg::*;
  logic          valid;
  logic          ready;
  logic [DW-1:0] distance;
  logic          lines_parallel;
  logic          saturated;

  modport source (output valid, distance, lines_parallel, saturated, input ready);
  modport sink (input valid, distance, lines_parallel, saturated, output ready);
endinterface

FILE: rtl/lld_div.sv
// Dual restoring divider, one quotient bit per stage for both line parameters.
// Depends on lld_pkg.
module lld_div (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  lld_pkg::dreq_t req,
  output logic out_vld,
  output lld_pkg::dres_t res
);
  import lld_pkg::*;

  logic [DSTEPS:0] vld_r;
  dstage_t         st_r [DSTEPS+1];
  dstage_t         st0_nxt;

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t       o;
    logic [RW-1:0] t1;
    logic [RW-1:0] t2;
    logic          b1;
    logic          b2;
    o    = s;
    t1   = {s.r1[RW-2:0], s.n1[QW-1]};
    t2   = {s.r2[RW-2:0], s.n2[QW-1]};
    b1   = t1 >= RW'(s.d);
    b2   = t2 >= RW'(s.d);
    o.r1 = b1 ? t1 - RW'(s.d) : t1;
    o.r2 = b2 ? t2 - RW'(s.d) : t2;
    o.n1 = {s.n1[QW-2:0], 1'b0};
    o.n2 = {s.n2[QW-2:0], 1'b0};
    o.q1 = {s.q1[QW-2:0], b1};
    o.q2 = {s.q2[QW-2:0], b2};
    return o;
  endfunction

  always_comb begin
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
    n1           = {req.nmag1, {FRAC_BITS{1'b0}}};
    n2           = {req.nmag2, {FRAC_BITS{1'b0}}};
    st0_nxt.d    = req.dmag;
    st0_nxt.ovf1 = MAGW'(n1[NW-1:QW]) >= req.dmag;
    st0_nxt.ovf2 = MAGW'(n2[NW-1:QW]) >= req.dmag;
    st0_nxt.r1   = st0_nxt.ovf1 ? '0 : RW'(n1[NW-1:QW]);
    st0_nxt.r2   = st0_nxt.ovf2 ? '0 : RW'(n2[NW-1:QW]);
    st0_nxt.n1   = n1[QW-1:0];
    st0_nxt.n2   = n2[QW-1:0];
    st0_nxt.q1   = '0;
    st0_nxt.q2   = '0;
    st0_nxt.side = req.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DSTEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 1; k <= DSTEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign out_vld  = vld_r[DSTEPS];
  assign res.q1   = st_r[DSTEPS].q1;
  assign res.q2   = st_r[DSTEPS].q2;
  assign res.ovf1 = st_r[DSTEPS].ovf1;
  assign res.ovf2 = st_r[DSTEPS].ovf2;
  assign res.side = st_r[DSTEPS].side;
endmodule

FILE: rtl/lld_sqrt.sv
// Pipelined integer square root, one root bit per stage, flags carried along.
// Depends on lld_pkg.
module lld_sqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  lld_pkg::sreq_t req,
  output logic out_vld,
  output lld_pkg::sres_t res
);
  import lld_pkg::*;

  logic [ROOTW:0] vld_r;
  sqst_t          st_r [ROOTW+1];

  function automatic sqst_t sq_step(input sqst_t s, input int k);
    sqst_t           o;
    logic [CSQW-1:0] cand;
    o    = s;
    cand = s.sq + (CSQW'(s.root) << (k + 1)) + (CSQW'(1) << (2 * k));
    if (CSQW'(s.sum) >= cand) begin
      o.root = s.root | (ROOTW'(1) << k);
      o.sq   = cand;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ROOTW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].sum  <= req.sum;
      st_r[0].root <= '0;
      st_r[0].sq   <= '0;
      st_r[0].flg  <= req.flg;
    end
  end

  for (genvar j = 1; j <= ROOTW; j++) begin : g_bit
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= sq_step(st_r[j-1], ROOTW - j);
      end
    end
  end

  assign out_vld  = vld_r[ROOTW];
  assign res.root = st_r[ROOTW].root;
  assign res.flg  = st_r[ROOTW].flg;
endmodule

FILE: rtl/line_line_distance.sv
// Closest distance between two 3D lines, Q16.16 fixed point.
// Throughput one pair per cycle; the whole pipeline holds while a result
// waits at the output. The 64-stage parameter divider and 34-stage square
// root set the depth. Reset (synchronous, active low) clears all valid bits;
// payload is not reset.
module line_line_distance (
  input logic clk,
  input logic rst_n,
  lld_in_if.sink    in_ch,
  lld_out_if.source out_ch
);
  import lld_pkg::*;

  logic adv;

  logic  s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic  s8_vld_r, s9_vld_r, s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r, s14_vld_r;
  logic  out_vld_r;

  side_t s1_sd_r, s2_sd_r, s3_sd_r, s4_sd_r, s5_sd_r, s6_sd_r;
  side_t s1_sd_nxt, s7_sd_nxt;
  side_t s8_sd_r, s9_sd_r, s10_sd_r;

  logic signed [PRODW-1:0] s2_p_nxt [5][3];
  logic signed [PRODW-1:0] s2_p_r   [5][3];
  logic signed [DOTW-1:0]  s3_dot_r [5];
  pp_t                     s4_pp_r  [6];
  logic signed [BIGW-1:0]  s5_big_r [6];
  logic signed [PW-1:0]    s6_den_r, s6_num1_r, s6_num2_r;
  dreq_t                   s7_req_r, s7_req_nxt;

  logic  dv_vld;
  dres_t dv_res;

  logic signed [TW-1:0]     s8_t1_r, s8_t2_r, s8_t1_nxt, s8_t2_nxt;
  logic signed [2*XW:0]     s9_l1_r [3];
  logic signed [2*XW:0]     s9_l2_r [3];
  logic signed [2*XW-1:0]   s9_h1_r [3];
  logic signed [2*XW-1:0]   s9_h2_r [3];
  logic signed [RNDW-1:0]   s10_r1_r [3];
  logic signed [RNDW-1:0]   s10_r2_r [3];
  logic signed [RNDW-1:0]   s10_r1_nxt [3];
  logic signed [RNDW-1:0]   s10_r2_nxt [3];
  logic signed [GW-1:0]     s11_g_r [3];
  logic                     s11_par_r;
  logic [DW-1:0]            s12_mag_r [3];
  logic [DW-1:0]            s12_mag_nxt [3];
  sflag_t                   s12_flg_r, s12_flg_nxt;
  logic [SQW-1:0]           s13_sq_r [3];
  sflag_t                   s13_flg_r;
  sreq_t                    s14_req_r;

  logic  sq_vld;
  sres_t sq_res;
  logic  root_big;

  logic [DW-1:0] out_dist_r;
  logic          out_par_r;
  logic          out_sat_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    s1_sd_nxt.u[0] = in_ch.first_dir_x;
    s1_sd_nxt.u[1] = in_ch.first_dir_y;
    s1_sd_nxt.u[2] = in_ch.first_dir_z;
    s1_sd_nxt.v[0] = in_ch.second_dir_x;
    s1_sd_nxt.v[1] = in_ch.second_dir_y;
    s1_sd_nxt.v[2] = in_ch.second_dir_z;
    s1_sd_nxt.w[0] = {in_ch.first_point_x[XW-1], in_ch.first_point_x}
                   - {in_ch.second_point_x[XW-1], in_ch.second_point_x};
    s1_sd_nxt.w[1] = {in_ch.first_point_y[XW-1], in_ch.first_point_y}
                   - {in_ch.second_point_y[XW-1], in_ch.second_point_y};
    s1_sd_nxt.w[2] = {in_ch.first_point_z[XW-1], in_ch.first_point_z}
                   - {in_ch.second_point_z[XW-1], in_ch.second_point_z};
    s1_sd_nxt.neg1 = 1'b0;
    s1_sd_nxt.neg2 = 1'b0;
    s1_sd_nxt.par  = 1'b0;
  end

  always_comb begin
    logic signed [WW-1:0] ue;
    logic signed [WW-1:0] ve;
    logic signed [WW-1:0] we;
    for (int i = 0; i < 3; i++) begin
      ue = $signed({s1_sd_r.u[i][XW-1], s1_sd_r.u[i]});
      ve = $signed({s1_sd_r.v[i][XW-1], s1_sd_r.v[i]});
      we = $signed(s1_sd_r.w[i]);
      s2_p_nxt[0][i] = ue * ue;
      s2_p_nxt[1][i] = ue * ve;
      s2_p_nxt[2][i] = ve * ve;
      s2_p_nxt[3][i] = we * ue;
      s2_p_nxt[4][i] = we * ve;
    end
  end

  always_comb begin
    logic signed [PW-1:0] dm;
    s7_sd_nxt      = s6_sd_r;
    s7_sd_nxt.neg1 = s6_num1_r[PW-1] ^ s6_den_r[PW-1];
    s7_sd_nxt.neg2 = s6_num2_r[PW-1] ^ s6_den_r[PW-1];
    s7_sd_nxt.par  = s6_den_r == '0;
    dm                = s6_den_r[PW-1] ? -s6_den_r : s6_den_r;
    s7_req_nxt.dmag   = MAGW'(dm);
    s7_req_nxt.nmag1  = MAGW'(s6_num1_r[PW-1] ? -s6_num1_r : s6_num1_r);
    s7_req_nxt.nmag2  = MAGW'(s6_num2_r[PW-1] ? -s6_num2_r : s6_num2_r);
    s7_req_nxt.side   = s7_sd_nxt;
  end

  lld_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s7_vld_r),
    .req     (s7_req_r),
    .out_vld (dv_vld),
    .res     (dv_res)
  );

  always_comb begin
    logic [QW-1:0] m1;
    logic [QW-1:0] m2;
    m1 = (dv_res.ovf1 || dv_res.q1 > T_LIMIT) ? T_LIMIT : dv_res.q1;
    m2 = (dv_res.ovf2 || dv_res.q2 > T_LIMIT) ? T_LIMIT : dv_res.q2;
    s8_t1_nxt = dv_res.side.neg1 ? -$signed(TW'(m1)) : $signed(TW'(m1));
    s8_t2_nxt = dv_res.side.neg2 ? -$signed(TW'(m2)) : $signed(TW'(m2));
  end

  always_comb begin
    logic signed [TPW-1:0] pr1;
    logic signed [TPW-1:0] pr2;
    for (int i = 0; i < 3; i++) begin
      pr1 = (TPW'(s9_h1_r[i]) <<< XW) + TPW'(s9_l1_r[i])
          + (TPW'(1) << (FRAC_BITS - 1));
      pr2 = (TPW'(s9_h2_r[i]) <<< XW) + TPW'(s9_l2_r[i])
          + (TPW'(1) << (FRAC_BITS - 1));
      s10_r1_nxt[i] = pr1[TPW-1:FRAC_BITS];
      s10_r2_nxt[i] = pr2[TPW-1:FRAC_BITS];
    end
  end

  always_comb begin
    logic signed [GW-1:0] gm;
    s12_flg_nxt.par = s11_par_r;
    s12_flg_nxt.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      gm             = s11_g_r[i][GW-1] ? -s11_g_r[i] : s11_g_r[i];
      s12_mag_nxt[i] = gm[DW-1:0];
      if (|gm[GW-1:DW]) begin
        s12_flg_nxt.sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
      s14_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= dv_vld;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= s9_vld_r;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      s13_vld_r <= s12_vld_r;
      s14_vld_r <= s13_vld_r;
      out_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sd_r <= s1_sd_nxt;
      s2_sd_r <= s1_sd_r;
      s2_p_r  <= s2_p_nxt;
      s3_sd_r <= s2_sd_r;
      for (int k = 0; k < 5; k++) begin
        s3_dot_r[k] <= dot_round(s2_p_r[k][0], s2_p_r[k][1], s2_p_r[k][2]);
      end
      s4_sd_r    <= s3_sd_r;
      s4_pp_r[0] <= pp_make(s3_dot_r[1], s3_dot_r[1]);
      s4_pp_r[1] <= pp_make(s3_dot_r[0], s3_dot_r[2]);
      s4_pp_r[2] <= pp_make(s3_dot_r[2], s3_dot_r[3]);
      s4_pp_r[3] <= pp_make(s3_dot_r[1], s3_dot_r[4]);
      s4_pp_r[4] <= pp_make(s3_dot_r[1], s3_dot_r[3]);
      s4_pp_r[5] <= pp_make(s3_dot_r[0], s3_dot_r[4]);
      s5_sd_r <= s4_sd_r;
      for (int k = 0; k < 6; k++) begin
        s5_big_r[k] <= pp_join(s4_pp_r[k]);
      end
      s6_sd_r   <= s5_sd_r;
      s6_den_r  <= PW'(s5_big_r[0]) - PW'(s5_big_r[1]);
      s6_num1_r <= PW'(s5_big_r[2]) - PW'(s5_big_r[3]);
      s6_num2_r <= PW'(s5_big_r[4]) - PW'(s5_big_r[5]);
      s7_req_r  <= s7_req_nxt;
      s8_sd_r   <= dv_res.side;
      s8_t1_r   <= s8_t1_nxt;
      s8_t2_r   <= s8_t2_nxt;
      s9_sd_r   <= s8_sd_r;
      for (int i = 0; i < 3; i++) begin
        s9_l1_r[i] <= $signed({1'b0, s8_t1_r[XW-1:0]}) * $signed(s8_sd_r.u[i]);
        s9_l2_r[i] <= $signed({1'b0, s8_t2_r[XW-1:0]}) * $signed(s8_sd_r.v[i]);
        s9_h1_r[i] <= $signed(s8_t1_r[TW-1:XW]) * $signed(s8_sd_r.u[i]);
        s9_h2_r[i] <= $signed(s8_t2_r[TW-1:XW]) * $signed(s8_sd_r.v[i]);
      end
      s10_sd_r <= s9_sd_r;
      s10_r1_r <= s10_r1_nxt;
      s10_r2_r <= s10_r2_nxt;
      s11_par_r <= s10_sd_r.par;
      for (int i = 0; i < 3; i++) begin
        s11_g_r[i] <= GW'($signed(s10_sd_r.w[i])) + GW'(s10_r1_r[i]) - GW'(s10_r2_r[i]);
      end
      s12_mag_r <= s12_mag_nxt;
      s12_flg_r <= s12_flg_nxt;
      for (int i = 0; i < 3; i++) begin
        s13_sq_r[i] <= s12_mag_r[i] * s12_mag_r[i];
      end
      s13_flg_r     <= s12_flg_r;
      s14_req_r.sum <= SSW'(s13_sq_r[0]) + SSW'(s13_sq_r[1]) + SSW'(s13_sq_r[2]);
      s14_req_r.flg <= s13_flg_r;
    end
  end

  lld_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s14_vld_r),
    .req     (s14_req_r),
    .out_vld (sq_vld),
    .res     (sq_res)
  );

  assign root_big = |sq_res.root[ROOTW-1:DW];

  always_ff @(posedge clk) begin
    if (adv) begin
      out_par_r <= sq_res.flg.par;
      out_sat_r <= !sq_res.flg.par && (sq_res.flg.sat || root_big);
      if (sq_res.flg.par) begin
        out_dist_r <= '0;
      end else if (sq_res.flg.sat || root_big) begin
        out_dist_r <= '1;
      end else begin
        out_dist_r <= sq_res.root[DW-1:0];
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.distance       = out_dist_r;
  assign out_ch.lines_parallel = out_par_r;
  assign out_ch.saturated      = out_sat_r;
endmodule

FILE: rtl/lld_check.sv
// Port-level checks for line_line_distance, attached by bind.
// Depends on lld_pkg and the top level's channel interfaces.
module lld_check (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [lld_pkg::DW-1:0] distance,
  input logic                  lines_parallel,
  input logic                  saturated
);
  import lld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance))
    else $error("result dropped or changed while stalled");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && lines_parallel |-> distance == '0 && !saturated)
    else $error("parallel result not zero");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> distance == '1)
    else $error("saturated result not at maximum");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind line_line_distance lld_check u_lld_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .distance       (out_ch.distance),
  .lines_parallel (out_ch.lines_parallel),
  .saturated      (out_ch.saturated)
);

FILE: tb/lld_checker.sv
`timescale 1ns / 100ps
// Checker for line_line_distance: watches both channels, predicts each
// distance result from the accepted line pair and compares. Depends on
// lld_pkg, lld_in_if and lld_out_if.
module lld_checker (
  input  logic      clk,
  input  logic      rst_n,
  lld_in_if         in_ch,
  lld_out_if        out_ch,
  output int        fail_count,
  output int        pending
);
  import lld_pkg::*;

  typedef logic signed [129:0] wide_t;

  typedef struct {
    logic [DW-1:0] distance;
    logic          lines_parallel;
    logic          saturated;
  } dist_res_t;

  dist_res_t expected_dist[$];
  int        fails = 0;

  assign fail_count = fails;

  function automatic wide_t rnd_frac(wide_t x);
    return (x + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic wide_t line_param(wide_t num, wide_t den);
    wide_t nm;
    wide_t dm;
    wide_t quo;
    nm  = num < 0 ? -num : num;
    dm  = den < 0 ? -den : den;
    quo = (nm <<< FRAC_BITS) / dm;
    if (quo > (wide_t'(1) <<< 62)) quo = wide_t'(1) <<< 62;
    return ((num < 0) != (den < 0)) ? -quo : quo;
  endfunction

  function automatic dist_res_t predict_distance(wide_t pp[3], wide_t uu[3],
                                                 wide_t qq[3], wide_t vv[3]);
    wide_t     w[3];
    wide_t     a, b, c, d, e, den, t1, t2, g, sum, root, cand;
    dist_res_t r;
    r.distance = '0;
    r.lines_parallel = 1'b0;
    r.saturated = 1'b0;
    for (int i = 0; i < 3; i++) w[i] = pp[i] - qq[i];
    a = rnd_frac(uu[0] * uu[0] + uu[1] * uu[1] + uu[2] * uu[2]);
    b = rnd_frac(uu[0] * vv[0] + uu[1] * vv[1] + uu[2] * vv[2]);
    c = rnd_frac(vv[0] * vv[0] + vv[1] * vv[1] + vv[2] * vv[2]);
    d = rnd_frac(w[0] * uu[0] + w[1] * uu[1] + w[2] * uu[2]);
    e = rnd_frac(w[0] * vv[0] + w[1] * vv[1] + w[2] * vv[2]);
    den = b * b - a * c;
    if (den == 0) begin
      r.lines_parallel = 1'b1;
      return r;
    end
    t1 = line_param(c * d - b * e, den);
    t2 = line_param(d * b - a * e, den);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      g = w[i] + rnd_frac(t1 * uu[i]) - rnd_frac(t2 * vv[i]);
      if (g < 0) g = -g;
      if (g >= (wide_t'(1) <<< 32)) r.saturated = 1'b1;
      sum = sum + g * g;
    end
    if (!r.saturated) begin
      root = 0;
      for (int k = 33; k >= 0; k--) begin
        cand = root | (wide_t'(1) <<< k);
        if (cand * cand <= sum) root = cand;
      end
      if (root > wide_t'(32'hFFFF_FFFF)) r.saturated = 1'b1;
      else r.distance = root[DW-1:0];
    end
    if (r.saturated) r.distance = '1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    wide_t     pp[3], uu[3], qq[3], vv[3];
    dist_res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        pp[0] = wide_t'($signed(in_ch.first_point_x));
        pp[1] = wide_t'($signed(in_ch.first_point_y));
        pp[2] = wide_t'($signed(in_ch.first_point_z));
        uu[0] = wide_t'($signed(in_ch.first_dir_x));
        uu[1] = wide_t'($signed(in_ch.first_dir_y));
        uu[2] = wide_t'($signed(in_ch.first_dir_z));
        qq[0] = wide_t'($signed(in_ch.second_point_x));
        qq[1] = wide_t'($signed(in_ch.second_point_y));
        qq[2] = wide_t'($signed(in_ch.second_point_z));
        vv[0] = wide_t'($signed(in_ch.second_dir_x));
        vv[1] = wide_t'($signed(in_ch.second_dir_y));
        vv[2] = wide_t'($signed(in_ch.second_dir_z));
        expected_dist.push_back(predict_distance(pp, uu, qq, vv));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch("unexpected transfer", out_ch.distance, '0);
        end else begin
          want = expected_dist.pop_front();
          if (out_ch.distance !== want.distance)
            report_mismatch("distance", out_ch.distance, want.distance);
          if (out_ch.lines_parallel !== want.lines_parallel)
            report_mismatch("lines_parallel", DW'(out_ch.lines_parallel),
                            DW'(want.lines_parallel));
          if (out_ch.saturated !== want.saturated)
            report_mismatch("saturated", DW'(out_ch.saturated), DW'(want.saturated));
        end
      end
    end
    pending <= expected_dist.size();
  end
endmodule

FILE: tb/tb_line_line_distance.sv
`timescale 1ns / 100ps
// Top of the line_line_distance testbench: clock, reset, line-pair stimulus
// and result back-pressure; lld_checker predicts and compares. Depends on
// lld_pkg, lld_in_if, lld_out_if, lld_checker and the block.
module tb_line_line_distance;
  import lld_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;

  typedef logic [11:0][XW-1:0] pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   out_count = 0;
  bit   no_idle = 1'b0;
  pair_t stim[$];

  lld_in_if  in_ch ();
  lld_out_if out_ch ();

  line_line_distance u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  lld_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic pair_t make_pair(logic [XW-1:0] px, logic [XW-1:0] py, logic [XW-1:0] pz,
                                      logic [XW-1:0] ux, logic [XW-1:0] uy, logic [XW-1:0] uz,
                                      logic [XW-1:0] qx, logic [XW-1:0] qy, logic [XW-1:0] qz,
                                      logic [XW-1:0] vx, logic [XW-1:0] vy, logic [XW-1:0] vz);
    return {vz, vy, vx, qz, qy, qx, uz, uy, ux, pz, py, px};
  endfunction

  function automatic logic [XW-1:0] rand_coord(int mode);
    case (mode)
      0: return XW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      1: return XW'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t it;
    int    mode;
    mode = $urandom_range(0, 5);
    for (int i = 0; i < 12; i++) it[i] = rand_coord(mode % 3);
    // bias toward near-parallel directions to reach huge line parameters
    if (mode == 5) begin
      for (int i = 9; i < 12; i++) it[i] = it[i - 6] + XW'($urandom_range(0, 3));
    end
    return it;
  endfunction

  initial begin
    localparam logic [XW-1:0] ONE = 32'h0001_0000;
    localparam logic [XW-1:0] MX  = 32'h7FFF_FFFF;
    localparam logic [XW-1:0] MN  = 32'h8000_0000;
    stim.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0));
    stim.push_back(make_pair(ONE, 0, 0, ONE, ONE, 0, 0, ONE, 0, ONE, ONE, 0));
    stim.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, 0, 3 * ONE, 0, -ONE, 0));
    stim.push_back(make_pair(MX, MX, MX, MX, MX, MX, MN, MN, MN, MN, MX, MN));
    stim.push_back(make_pair(MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN));
    stim.push_back(make_pair(MX, MX, MX, ONE, 0, 0, MN, MN, MN, 0, ONE, 0));
    stim.push_back(make_pair(MN, MX, MN, 0, 0, ONE, MX, MN, MX, ONE, 0, 0));
    stim.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 1, 0));
    stim.push_back(make_pair(0, 0, 0, MX, MX, MX, MX, 0, 0, MX, MX, MX - 1));
    stim.push_back(make_pair(1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0));
    stim.push_back(make_pair(MX, MN, 0, MN, 0, MX, 0, MX, MN, MX, MN, 0));
    stim.push_back(make_pair(-1, -1, -1, -1, 1, 0, 1, 1, 1, 1, 1, -1));
    stim.push_back(make_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, 0, 0));
    for (int i = 0; i < RANDOM_ITEMS; i++) stim.push_back(rand_pair());

    in_ch.valid <= 1'b0;
    {in_ch.first_point_x, in_ch.first_point_y, in_ch.first_point_z} <= '0;
    {in_ch.first_dir_x, in_ch.first_dir_y, in_ch.first_dir_z} <= '0;
    {in_ch.second_point_x, in_ch.second_point_y, in_ch.second_point_z} <= '0;
    {in_ch.second_dir_x, in_ch.second_dir_y, in_ch.second_dir_z} <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim[n]) begin
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (n % 150 == 100) no_idle = !no_idle;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      {in_ch.second_dir_z, in_ch.second_dir_y, in_ch.second_dir_x,
       in_ch.second_point_z, in_ch.second_point_y, in_ch.second_point_x,
       in_ch.first_dir_z, in_ch.first_dir_y, in_ch.first_dir_x,
       in_ch.first_point_z, in_ch.first_point_y, in_ch.first_point_x} <= stim[n];
      in_ch.valid <= 1'b1;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to fill the pipeline
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (out_count == 100) gap = 400;
      else gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      out_count++;
    end
  end
endmodule

FILE: sim.f
rtl/lld_pkg.sv
rtl/lld_in_if.sv
rtl/lld_out_if.sv
rtl/lld_div.sv
rtl/lld_sqrt.sv
rtl/line_line_distance.sv
rtl/lld_check.sv
tb/lld_checker.sv
tb/tb_line_line_distance.sv
